// ===== design/atps_pkg.sv =====
`default_nettype none
package atps_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int ANGLE_BITS = 16;
   localparam int POS_FRAC_BITS = 8;

   // bit-serial multiplier: serial operand, parallel operand, product
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_A_W);

   // restoring divider
   localparam int DIV_N_W = 46;
   localparam int DIV_D_W = 32;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   localparam int CORDIC_W = 35;
   localparam int CORDIC_Z_W = 33;
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);

   localparam logic [MUL_B_W-1:0] INV_GAIN_Q30 = 32'd652032874;
   localparam logic [MUL_B_W-1:0] TURNS_PER_RAD_Q32 = 32'd683565276;

   // chord rounding shift and width of the rounded magnitude
   localparam int CHORD_SH = 30 - POS_FRAC_BITS;
   localparam int CHORD_M_W = MUL_P_W - CHORD_SH;

   localparam logic [1:0] CSR_SPEED = 2'd0;
   localparam logic [1:0] CSR_PATH = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;
   localparam logic [1:0] CSR_RATE = 2'd3;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic [1:0] {
      STAT_STEPPED = 2'd0,
      STAT_NO_STEP = 2'd1,
      STAT_INVALID = 2'd2,
      STAT_LOADED  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_D_CHECK,
      ST_D_MUL_N,
      ST_D_MUL_D,
      ST_D_MUL_K,
      ST_D_DIV_C,
      ST_D_DIV_A,
      ST_D_ROT,
      ST_D_CX,
      ST_D_CY,
      ST_T_ROT,
      ST_FIN
   } state_type;

   typedef logic [31:0] atan_table_type [0:ATAN_DEPTH-1];

   // atan(2^-i) in turns, Q32
   localparam atan_table_type ATAN_TURNS = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   function automatic logic [CORDIC_W-1:0] abs_c(input logic signed [CORDIC_W-1:0] v);
      logic [CORDIC_W-1:0] r;
      r = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic neg, input logic [CHORD_M_W-1:0] m);
      logic [31:0] r;
      if (neg) begin
         if (m > CHORD_M_W'(33'h0_8000_0000)) r = 32'h8000_0000;
         else r = 32'(-m);
      end else begin
         if (m > CHORD_M_W'(32'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
         else r = m[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/atps_req_if.sv =====
`default_nettype none
interface atps_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic signed [31:0] load_x;
   logic signed [31:0] load_y;
   logic [15:0] load_heading;

   modport source (output valid, req_type, load_x, load_y, load_heading, input ready);
   modport sink (input valid, req_type, load_x, load_y, load_heading, output ready);
endinterface
`default_nettype wire

// ===== design/atps_rsp_if.sv =====
`default_nettype none
interface atps_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] pos_x_out;
   logic signed [31:0] pos_y_out;
   logic [15:0] heading_out;
   logic [1:0] status;

   modport source (output valid, pos_x_out, pos_y_out, heading_out, status, input ready);
   modport sink (input valid, pos_x_out, pos_y_out, heading_out, status, output ready);
endinterface
`default_nettype wire

// ===== design/atps_smul.sv =====
`default_nettype none
module atps_smul (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [atps_pkg::MUL_A_W-1:0] a,
   input  wire logic [atps_pkg::MUL_B_W-1:0] b,
   output logic done,
   output logic [atps_pkg::MUL_P_W-1:0] prod
);
   import atps_pkg::*;

   logic [MUL_P_W-1:0] p_ff, p_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [MUL_B_W:0] sum;

   // one bit of a per cycle, lsb first; partial sum shifts right
   always_comb begin
      sum = {1'b0, p_ff[MUL_P_W-1:MUL_A_W]} + (p_ff[0] ? {1'b0, b} : '0);
      p_in = p_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         p_in = {{MUL_B_W{1'b0}}, a};
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in = {sum, p_ff[MUL_A_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_A_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = p_ff;
endmodule
`default_nettype wire

// ===== design/atps_sdiv.sv =====
`default_nettype none
module atps_sdiv (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [atps_pkg::DIV_N_W-1:0] num,
   input  wire logic [atps_pkg::DIV_D_W-1:0] den,
   output logic done,
   output logic [atps_pkg::DIV_N_W-1:0] quot
);
   import atps_pkg::*;

   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_N_W-1:0] q_ff, q_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DIV_D_W:0] trial, diff;
   logic ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, q_ff[DIV_N_W-1]};
      diff = trial - {1'b0, den};
      ge = trial >= {1'b0, den};
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         q_in = num;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         q_in = {q_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ===== design/atps_cordic.sv =====
`default_nettype none
module atps_cordic (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [31:0] x_in,
   input  wire logic signed [31:0] y_in,
   input  wire logic [31:0] ang,
   output logic done,
   output logic signed [atps_pkg::CORDIC_W-1:0] x_out,
   output logic signed [atps_pkg::CORDIC_W-1:0] y_out
);
   import atps_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, x_in_d, y_ff, y_in_d;
   logic signed [CORDIC_Z_W-1:0] z_ff, z_in;
   logic [ATAN_IDX_W-1:0] i_ff, i_in;
   logic iter_ff, iter_in;
   logic mstart_ff, mstart_in;
   logic done_ff;
   logic signed [CORDIC_W-1:0] xo_ff, yo_ff;

   logic [31:0] angq, res;
   logic [1:0] q;
   logic signed [CORDIC_W-1:0] xs, ys, x0, y0, dx, dy;
   logic signed [CORDIC_Z_W-1:0] at;
   logic mx_done, my_done;
   logic [MUL_P_W-1:0] mx_prod, my_prod, rx, ry;
   logic [CORDIC_W-1:0] x_mag, y_mag;

   always_comb begin
      // exact quarter-turn pre-rotation toward the nearest quadrant
      angq = ang + 32'h2000_0000;
      q = angq[31:30];
      res = ang - {q, 30'b0};
      xs = {{(CORDIC_W-32){x_in[31]}}, x_in};
      ys = {{(CORDIC_W-32){y_in[31]}}, y_in};
      case (q)
         2'd0: begin
            x0 = xs;
            y0 = ys;
         end
         2'd1: begin
            x0 = -ys;
            y0 = xs;
         end
         2'd2: begin
            x0 = -xs;
            y0 = -ys;
         end
         2'd3: begin
            x0 = ys;
            y0 = -xs;
         end
         default: begin
            x0 = xs;
            y0 = ys;
         end
      endcase
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      at = {1'b0, ATAN_TURNS[i_ff]};

      x_in_d = x_ff;
      y_in_d = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      iter_in = iter_ff;
      mstart_in = 1'b0;
      if (start) begin
         x_in_d = x0;
         y_in_d = y0;
         z_in = {res[31], res};
         i_in = '0;
         iter_in = 1'b1;
      end else if (iter_ff) begin
         if (!z_ff[CORDIC_Z_W-1]) begin
            x_in_d = x_ff - dx;
            y_in_d = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in_d = x_ff + dx;
            y_in_d = y_ff - dy;
            z_in = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == ATAN_IDX_W'(CORDIC_ITERATIONS - 1)) begin
            iter_in = 1'b0;
            mstart_in = 1'b1;
         end
      end

      // gain correction, rounded half away from zero
      rx = mx_prod + (MUL_P_W'(1) << 29);
      ry = my_prod + (MUL_P_W'(1) << 29);
      x_mag = rx[CORDIC_W+29:30];
      y_mag = ry[CORDIC_W+29:30];
   end

   atps_smul u_mul_x (
      .clock(clock), .reset(reset), .start(mstart_ff),
      .a(abs_c(x_ff)), .b(INV_GAIN_Q30), .done(mx_done), .prod(mx_prod)
   );

   atps_smul u_mul_y (
      .clock(clock), .reset(reset), .start(mstart_ff),
      .a(abs_c(y_ff)), .b(INV_GAIN_Q30), .done(my_done), .prod(my_prod)
   );

   always_ff @(posedge clock) begin
      x_ff <= x_in_d;
      y_ff <= y_in_d;
      z_ff <= z_in;
      i_ff <= i_in;
      if (mx_done) begin
         xo_ff <= x_ff[CORDIC_W-1] ? -$signed(x_mag) : $signed(x_mag);
         yo_ff <= y_ff[CORDIC_W-1] ? -$signed(y_mag) : $signed(y_mag);
      end
      if (reset) begin
         iter_ff <= 1'b0;
         mstart_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         iter_ff <= iter_in;
         mstart_ff <= mstart_in;
         done_ff <= mx_done && my_done;
      end
   end

   assign done = done_ff;
   assign x_out = xo_ff;
   assign y_out = yo_ff;
endmodule
`default_nettype wire

// ===== design/arc_turn_pose_stepper_core.sv =====
`default_nettype none
// Arc turn pose stepper. Each write to a csr register re-derives the turn command (step
// count, per-step heading change and local chord), or clears it when the parameters are
// invalid or the path is zero, with req_bus.ready low meanwhile; the derivation takes five
// passes of the bit-serial multiplier, two restoring divisions and one CORDIC rotation. A
// load beat, a tick with invalid parameters and a tick after the command has finished raise
// rsp_bus.valid by way of the finish state, which waits until the output register is free.
// A stepping tick first passes a CORDIC launch, sixteen CORDIC micro-rotations, one per
// cycle, the bit-serial gain correction and the finish state. The next beat is taken as soon
// as the result has moved to the output register, even if rsp_bus has not taken it.
module arc_turn_pose_stepper_core (
   input  wire logic clock,
   input  wire logic reset,
   atps_req_if.sink req_bus,
   atps_rsp_if.source rsp_bus,
   input  wire logic csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [20:0] csr_wdata
);
   import atps_pkg::*;

   state_type state_ff, state_in;
   logic launch_ff, launch_in;

   logic signed [16:0] spd_ff, spd_in;
   logic signed [20:0] dist_ff, dist_in, rad_ff, rad_in;
   logic [11:0] rate_ff, rate_in;

   logic valid_ff, valid_in;
   logic [23:0] steps_done_ff, steps_done_in, steps_total_ff, steps_total_in;
   logic [31:0] chord_x_ff, chord_x_in, chord_y_ff, chord_y_in;
   logic [ANGLE_BITS-1:0] delta_ff, delta_in, hdg_ff, hdg_in;
   logic [31:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;

   logic [32:0] numc_ff, numc_in;
   logic [31:0] den_ff, den_in;
   logic [45:0] numa_ff, numa_in;
   logic signed [CORDIC_W-1:0] cs_c_ff, cs_c_in, cs_s_ff, cs_s_in;
   status_type status_ff, status_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [15:0] out_h_ff, out_h_in;
   status_type out_s_ff, out_s_in;

   logic [16:0] asp;
   logic [20:0] ads, ard;
   logic par_ok, turn_add, req_ready, req_acc;
   logic mul_start, div_start, cor_start;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic mul_done, div_done, cor_done;
   logic [MUL_P_W-1:0] mul_prod, rsum;
   logic [CHORD_M_W-1:0] chord_m;
   logic [DIV_N_W-1:0] div_num, div_q;
   logic [DIV_D_W-1:0] div_den;
   logic signed [31:0] cor_x, cor_y;
   logic [31:0] cor_ang;
   logic signed [CORDIC_W-1:0] cor_xo, cor_yo, cy_v;
   logic [32:0] frac_r;

   always_comb begin
      asp = spd_ff[16] ? 17'(-spd_ff) : 17'(spd_ff);
      ads = dist_ff[20] ? 21'(-dist_ff) : 21'(dist_ff);
      ard = rad_ff[20] ? 21'(-rad_ff) : 21'(rad_ff);
      par_ok = (rad_ff != 0) && (rate_ff != 0) && !((dist_ff == 0) && (spd_ff != 0))
               && !((spd_ff == 0) && (dist_ff != 0));
      turn_add = spd_ff[16] == rad_ff[20];
      req_ready = (state_ff == ST_IDLE) && !csr_we;
      req_acc = req_bus.valid && req_ready;
      cy_v = CORDIC_W'(36'sh0_4000_0000) - cs_c_ff;
      rsum = mul_prod + (MUL_P_W'(1) << (CHORD_SH - 1));
      chord_m = rsum[MUL_P_W-1:CHORD_SH];
      frac_r = {1'b0, div_q[31:0]} + (33'd1 << (31 - ANGLE_BITS));

      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_D_MUL_N: begin
            mul_a = MUL_A_W'(rate_ff);
            mul_b = MUL_B_W'(ads);
         end
         ST_D_MUL_D: begin
            mul_a = MUL_A_W'(rate_ff);
            mul_b = MUL_B_W'(ard);
         end
         ST_D_MUL_K: begin
            mul_a = MUL_A_W'(asp);
            mul_b = TURNS_PER_RAD_Q32;
         end
         ST_D_CX: begin
            mul_a = abs_c(cs_s_ff);
            mul_b = MUL_B_W'(ard);
         end
         ST_D_CY: begin
            mul_a = abs_c(cy_v);
            mul_b = MUL_B_W'(ard);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      if (state_ff == ST_D_DIV_A) begin
         div_num = numa_ff;
         div_den = den_ff;
      end else begin
         div_num = DIV_N_W'(numc_ff);
         div_den = DIV_D_W'(asp);
      end

      if (state_ff == ST_T_ROT) begin
         cor_x = chord_x_ff;
         cor_y = chord_y_ff;
         cor_ang = {hdg_ff, {(32-ANGLE_BITS){1'b0}}};
      end else begin
         cor_x = 32'sh4000_0000;
         cor_y = '0;
         cor_ang = {delta_ff, {(32-ANGLE_BITS){1'b0}}};
      end
   end

   atps_smul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_prod)
   );

   atps_sdiv u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .done(div_done), .quot(div_q)
   );

   atps_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cor_start),
      .x_in(cor_x), .y_in(cor_y), .ang(cor_ang),
      .done(cor_done), .x_out(cor_xo), .y_out(cor_yo)
   );

   always_comb begin
      state_in = state_ff;
      launch_in = launch_ff;
      spd_in = spd_ff;
      dist_in = dist_ff;
      rad_in = rad_ff;
      rate_in = rate_ff;
      valid_in = valid_ff;
      steps_done_in = steps_done_ff;
      steps_total_in = steps_total_ff;
      chord_x_in = chord_x_ff;
      chord_y_in = chord_y_ff;
      delta_in = delta_ff;
      hdg_in = hdg_ff;
      pose_x_in = pose_x_ff;
      pose_y_in = pose_y_ff;
      numc_in = numc_ff;
      den_in = den_ff;
      numa_in = numa_ff;
      cs_c_in = cs_c_ff;
      cs_s_in = cs_s_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_h_in = out_h_ff;
      out_s_in = out_s_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      cor_start = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_FIN;
               if (req_bus.req_type == REQ_LOAD) begin
                  pose_x_in = req_bus.load_x;
                  pose_y_in = req_bus.load_y;
                  hdg_in = req_bus.load_heading[ANGLE_BITS-1:0];
                  status_in = STAT_LOADED;
               end else if (!valid_ff) begin
                  status_in = STAT_INVALID;
               end else if (steps_done_ff < steps_total_ff) begin
                  state_in = ST_T_ROT;
                  launch_in = 1'b0;
               end else begin
                  status_in = STAT_NO_STEP;
               end
            end
         end
         ST_D_CHECK: begin
            valid_in = par_ok;
            steps_done_in = '0;
            steps_total_in = '0;
            delta_in = '0;
            chord_x_in = '0;
            chord_y_in = '0;
            launch_in = 1'b0;
            state_in = (par_ok && (ads != 0)) ? ST_D_MUL_N : ST_IDLE;
         end
         ST_D_MUL_N, ST_D_MUL_D, ST_D_MUL_K, ST_D_CX, ST_D_CY: begin
            if (!launch_ff) begin
               mul_start = 1'b1;
               launch_in = 1'b1;
            end else if (mul_done) begin
               launch_in = 1'b0;
               case (state_ff)
                  ST_D_MUL_N: begin
                     numc_in = mul_prod[32:0] + 33'(asp) - 33'd1;
                     state_in = ST_D_MUL_D;
                  end
                  ST_D_MUL_D: begin
                     den_in = mul_prod[31:0];
                     state_in = ST_D_MUL_K;
                  end
                  ST_D_MUL_K: begin
                     numa_in = mul_prod[45:0];
                     state_in = ST_D_DIV_C;
                  end
                  ST_D_CX: begin
                     chord_x_in = sat32(cs_s_ff[CORDIC_W-1] ^ spd_ff[16], chord_m);
                     state_in = ST_D_CY;
                  end
                  default: begin
                     chord_y_in = sat32(cy_v[CORDIC_W-1] ^ rad_ff[20], chord_m);
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_D_DIV_C, ST_D_DIV_A: begin
            if (!launch_ff) begin
               div_start = 1'b1;
               launch_in = 1'b1;
            end else if (div_done) begin
               launch_in = 1'b0;
               if (state_ff == ST_D_DIV_C) begin
                  steps_total_in = (|div_q[DIV_N_W-1:24]) ? 24'hFF_FFFF : div_q[23:0];
                  state_in = ST_D_DIV_A;
               end else begin
                  delta_in = frac_r[31:32-ANGLE_BITS];
                  state_in = ST_D_ROT;
               end
            end
         end
         ST_D_ROT, ST_T_ROT: begin
            if (!launch_ff) begin
               cor_start = 1'b1;
               launch_in = 1'b1;
            end else if (cor_done) begin
               launch_in = 1'b0;
               if (state_ff == ST_D_ROT) begin
                  cs_c_in = cor_xo;
                  cs_s_in = cor_yo;
                  state_in = ST_D_CX;
               end else begin
                  pose_x_in = pose_x_ff + cor_xo[31:0];
                  pose_y_in = pose_y_ff + cor_yo[31:0];
                  hdg_in = turn_add ? hdg_ff + delta_ff : hdg_ff - delta_ff;
                  steps_done_in = steps_done_ff + 24'd1;
                  status_in = STAT_STEPPED;
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               out_x_in = pose_x_ff;
               out_y_in = pose_y_ff;
               out_h_in = 16'(hdg_ff);
               out_s_in = status_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a register write restarts the derivation
      if (csr_we) begin
         case (csr_index)
            CSR_SPEED: spd_in = csr_wdata[16:0];
            CSR_PATH: dist_in = csr_wdata;
            CSR_RADIUS: rad_in = csr_wdata;
            CSR_RATE: rate_in = csr_wdata[11:0];
            default: rate_in = rate_ff;
         endcase
         state_in = ST_D_CHECK;
         launch_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      numc_ff <= numc_in;
      den_ff <= den_in;
      numa_ff <= numa_in;
      cs_c_ff <= cs_c_in;
      cs_s_ff <= cs_s_in;
      status_ff <= status_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_h_ff <= out_h_in;
      out_s_ff <= out_s_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         launch_ff <= 1'b0;
         spd_ff <= '0;
         dist_ff <= '0;
         rad_ff <= '0;
         rate_ff <= 12'd1;
         valid_ff <= 1'b0;
         steps_done_ff <= '0;
         steps_total_ff <= '0;
         chord_x_ff <= '0;
         chord_y_ff <= '0;
         delta_ff <= '0;
         hdg_ff <= '0;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         launch_ff <= launch_in;
         spd_ff <= spd_in;
         dist_ff <= dist_in;
         rad_ff <= rad_in;
         rate_ff <= rate_in;
         valid_ff <= valid_in;
         steps_done_ff <= steps_done_in;
         steps_total_ff <= steps_total_in;
         chord_x_ff <= chord_x_in;
         chord_y_ff <= chord_y_in;
         delta_ff <= delta_in;
         hdg_ff <= hdg_in;
         pose_x_ff <= pose_x_in;
         pose_y_ff <= pose_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.pos_x_out = out_x_ff;
   assign rsp_bus.pos_y_out = out_y_ff;
   assign rsp_bus.heading_out = out_h_ff;
   assign rsp_bus.status = out_s_ff;

   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (steps_done_ff <= steps_total_ff))
      else $error("step counter ran past the step total");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ST_IDLE))
      else $error("accepted beat did not leave idle");

   a_invalid_clears: assert property (@(posedge clock) disable iff (reset)
      (!valid_ff && (state_ff == ST_IDLE)) |-> ((steps_total_ff == 0) && (delta_ff == 0)))
      else $error("invalid command left derived values");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside the finish state");
endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
   import atps_pkg::*;

   typedef struct {
      logic        kind;
      logic [31:0] x;
      logic [31:0] y;
      logic [15:0] hdg;
   } pose_req_type;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [15:0] hdg;
      logic [1:0]  status;
   } pose_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_SPEED;
   logic [20:0] csr_wdata = '0;

   atps_req_if req_if ();
   atps_rsp_if rsp_if ();

   arc_turn_pose_stepper_core dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pose_req_type pending_reqs[$];
   pose_rsp_type expected_poses[$];
   int mismatches = 0;
   int rsp_seen = 0;

   // predictor state
   logic signed [16:0] m_speed;
   logic signed [20:0] m_path;
   logic signed [20:0] m_radius;
   logic [11:0] m_rate;
   logic [31:0] m_px, m_py;
   logic [15:0] m_hdg;
   logic [23:0] m_done, m_total;
   logic [31:0] m_chord_x, m_chord_y;
   logic [15:0] m_delta;

   function automatic longint round_away(longint v, int s);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic void cordic_rotate(inout longint px, inout longint py,
                                         input logic [31:0] ang);
      longint x, y, t, z, dx, dy;
      logic [1:0] q;
      logic [31:0] res;
      x = px;
      y = py;
      q = 2'((ang + 32'h2000_0000) >> 30);
      res = ang - {q, 30'b0};
      z = longint'($signed(res));
      if (q == 2'd1) begin
         t = x; x = -y; y = t;
      end else if (q == 2'd2) begin
         x = -x; y = -y;
      end else if (q == 2'd3) begin
         t = x; x = y; y = -t;
      end
      for (int i = 0; i < CORDIC_ITERATIONS && i < ATAN_DEPTH; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(ATAN_TURNS[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(ATAN_TURNS[i]);
         end
      end
      px = round_away(x * longint'(INV_GAIN_Q30), 30);
      py = round_away(y * longint'(INV_GAIN_Q30), 30);
   endfunction

   function automatic bit turn_cmd_valid();
      if (m_radius == 0 || m_rate == 0) return 1'b0;
      if (m_path == 0 && m_speed != 0) return 1'b0;
      if (m_speed == 0 && m_path != 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic void derive_turn();
      longint asp, ads, ard, cnt, frac, c, s, cx, cy;
      asp = (m_speed < 0) ? -longint'(m_speed) : longint'(m_speed);
      ads = (m_path < 0) ? -longint'(m_path) : longint'(m_path);
      ard = (m_radius < 0) ? -longint'(m_radius) : longint'(m_radius);
      m_done = '0;
      m_total = '0;
      m_delta = '0;
      m_chord_x = '0;
      m_chord_y = '0;
      if (!turn_cmd_valid() || ads == 0 || asp == 0) return;
      cnt = (longint'(m_rate) * ads + asp - 1) / asp;
      m_total = (cnt > 64'hFF_FFFF) ? 24'hFF_FFFF : cnt[23:0];
      frac = ((asp * longint'(TURNS_PER_RAD_Q32)) / (longint'(m_rate) * ard)) & 64'hFFFF_FFFF;
      frac = (frac + (64'd1 << 15)) >> 16;
      m_delta = frac[15:0];
      c = longint'(1) <<< 30;
      s = 0;
      cordic_rotate(c, s, {m_delta, 16'h0});
      cx = round_away(ard * s, 30 - POS_FRAC_BITS);
      cy = round_away(ard * ((longint'(1) <<< 30) - c), 30 - POS_FRAC_BITS);
      if (m_speed < 0) cx = -cx;
      if (m_radius < 0) cy = -cy;
      m_chord_x = clip32(cx);
      m_chord_y = clip32(cy);
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [20:0] val);
      case (idx)
         CSR_SPEED: m_speed = val[16:0];
         CSR_PATH: m_path = val;
         CSR_RADIUS: m_radius = val;
         default: m_rate = val[11:0];
      endcase
      derive_turn();
   endfunction

   function automatic pose_rsp_type step_pose(pose_req_type r);
      pose_rsp_type o;
      longint x, y;
      if (r.kind == REQ_LOAD) begin
         m_px = r.x;
         m_py = r.y;
         m_hdg = r.hdg;
         o.status = STAT_LOADED;
      end else if (!turn_cmd_valid()) begin
         o.status = STAT_INVALID;
      end else if (m_done < m_total) begin
         x = longint'($signed(m_chord_x));
         y = longint'($signed(m_chord_y));
         cordic_rotate(x, y, {m_hdg, 16'h0});
         m_px = m_px + x[31:0];
         m_py = m_py + y[31:0];
         if ((m_speed > 0 && m_radius > 0) || (m_speed < 0 && m_radius < 0))
            m_hdg = m_hdg + m_delta;
         else
            m_hdg = m_hdg - m_delta;
         m_done = m_done + 1;
         o.status = STAT_STEPPED;
      end else begin
         o.status = STAT_NO_STEP;
      end
      o.x = m_px;
      o.y = m_py;
      o.hdg = m_hdg;
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 13) return 0;
      if (r < 18) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // driver
   logic beat_taken = 1'b0;
   int send_gap = 0;
   bit gaps_on = 1'b1;
   pose_req_type cur;

   initial begin
      req_if.valid = 1'b0;
      req_if.req_type = REQ_TICK;
      req_if.load_x = '0;
      req_if.load_y = '0;
      req_if.load_heading = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         cur.kind = req_if.req_type;
         cur.x = req_if.load_x;
         cur.y = req_if.load_y;
         cur.hdg = req_if.load_heading;
         expected_poses.push_back(step_pose(cur));
         beat_taken <= 1'b1;
      end
   end

   always @(negedge clock) begin
      pose_req_type nx;
      if (!reset && (!req_if.valid || beat_taken)) begin
         beat_taken <= 1'b0;
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            nx = pending_reqs.pop_front();
            req_if.valid <= 1'b1;
            req_if.req_type <= nx.kind;
            req_if.load_x <= nx.x;
            req_if.load_y <= nx.y;
            req_if.load_heading <= nx.hdg;
            send_gap <= gaps_on ? pick_gap() : 0;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor
   int hold_off = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      pose_rsp_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_seen <= rsp_seen + 1;
         if (expected_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat x=%h", rsp_if.pos_x_out);
         end else begin
            e = expected_poses.pop_front();
            if (rsp_if.pos_x_out !== e.x || rsp_if.pos_y_out !== e.y ||
                rsp_if.heading_out !== e.hdg || rsp_if.status !== e.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp x=%h y=%h h=%h st=%0d got x=%h y=%h h=%h st=%0d",
                           e.x, e.y, e.hdg, e.status, rsp_if.pos_x_out, rsp_if.pos_y_out,
                           rsp_if.heading_out, rsp_if.status);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (!hold_done && rsp_seen >= 300 && pending_reqs.size() > 8) begin
         // long stall so the block backs up onto its input
         hold_done <= 1'b1;
         hold_off <= 600;
         rsp_if.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_if.ready <= 1'b0;
      end else if (!gaps_on) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
      end
   end

   // stimulus
   task automatic push_req(logic kind, logic [31:0] x, logic [31:0] y, logic [15:0] h);
      pose_req_type r;
      r.kind = kind;
      r.x = x;
      r.y = y;
      r.hdg = h;
      pending_reqs.push_back(r);
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_if.valid || expected_poses.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [20:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_csr(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
      repeat (400) @(negedge clock);
   endtask

   task automatic set_turn(int spd, int len, int rad, int rate);
      write_csr(CSR_SPEED, 21'(spd));
      write_csr(CSR_PATH, 21'(len));
      write_csr(CSR_RADIUS, 21'(rad));
      write_csr(CSR_RATE, 21'(rate));
   endtask

   function automatic int pick_cfg(int lim, bit can_neg);
      int r, v;
      r = $urandom_range(0, 9);
      if (r == 0) v = lim;
      else if (r == 1) v = 0;
      else if (r < 5) v = $urandom_range(1, 200);
      else v = $urandom_range(1, lim);
      if (can_neg && $urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   initial begin
      int n;
      m_speed = '0;
      m_path = '0;
      m_radius = '0;
      m_rate = 12'd1;
      m_px = '0;
      m_py = '0;
      m_hdg = '0;
      derive_turn();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (400) @(negedge clock);

      // reset config has zero radius
      push_req(REQ_TICK, 32'h0, 32'h0, 16'h0);
      push_req(REQ_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
      push_req(REQ_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
      push_req(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);

      // a few steps, then finished
      set_turn(1, 3, 1000, 1);
      for (int i = 0; i < 5; i++) push_req(REQ_TICK, $urandom, $urandom, $urandom);

      // extremes, reverse and opposite turn
      set_turn(-65535, 1048575, -1048575, 4095);
      push_req(REQ_LOAD, 32'h7FFF_FF00, 32'h7FFF_FF00, 16'h4000);
      for (int i = 0; i < 4; i++) push_req(REQ_TICK, 0, 0, 0);
      set_turn(65535, -1048575, 1, 1);
      for (int i = 0; i < 3; i++) push_req(REQ_TICK, 0, 0, 0);

      // zero distance with speed, zero speed with distance, both zero, zero rate
      set_turn(100, 0, 500, 10);
      push_req(REQ_TICK, 0, 0, 0);
      set_turn(0, 100, 500, 10);
      push_req(REQ_TICK, 0, 0, 0);
      write_csr(CSR_PATH, 21'd0);
      push_req(REQ_TICK, 0, 0, 0);
      set_turn(100, 100, 500, 0);
      push_req(REQ_TICK, 0, 0, 0);

      n = 0;
      while (n < 1250) begin
         set_turn(pick_cfg(65535, 1), pick_cfg(1048575, 1), pick_cfg(1048575, 1),
                  ($urandom_range(0, 19) == 0) ? 0 :
                  ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(1, 4095));
         // most commands get a valid pair so stepping is reached
         if (!turn_cmd_valid() && $urandom_range(0, 3) != 0) begin
            write_csr(CSR_RADIUS, 21'($urandom_range(1, 1048575)));
            write_csr(CSR_PATH, 21'($urandom_range(1, 5000)));
            write_csr(CSR_SPEED, 21'($urandom_range(1, 65535)));
            write_csr(CSR_RATE, 21'($urandom_range(1, 4095)));
         end
         gaps_on = ($urandom_range(0, 4) != 0);
         for (int i = $urandom_range(30, 70); i > 0; i--) begin
            if ($urandom_range(0, 9) == 0)
               push_req(REQ_LOAD, $urandom, $urandom, 16'($urandom));
            else
               push_req(REQ_TICK, $urandom, $urandom, 16'($urandom));
            n++;
         end
      end
      gaps_on = 1'b1;

      drain();
      repeat (100) @(negedge clock);
      if (mismatches == 0 && expected_poses.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #(12 * 3_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire
